/* rtl/core/jvls_pkg.sv */
// Shared constants and types for the joint velocity limit scaler.
package jvls_pkg;

	localparam int VALUE_BITS = 32;
	localparam int SCALE_BITS = 17;
	localparam int QUOT_BITS  = 16;
	localparam int CNT_BITS   = $clog2(QUOT_BITS + 1);

	localparam logic [SCALE_BITS-1:0] SCALE_ONE    = SCALE_BITS'(1) << QUOT_BITS;
	localparam logic [SCALE_BITS-1:0] OVERRIDE_MIN = SCALE_BITS'(655);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_PREP,
		ST_DIV,
		ST_FINISH
	} jvls_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} jvls_div_stat_t;

endpackage

/* rtl/core/jvls_divider.sv */
// Radix-2 restoring divider: floor(num * 2^QUOT_BITS / den) for num < den.
module jvls_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [jvls_pkg::VALUE_BITS-1:0]       num,
	input  logic [jvls_pkg::VALUE_BITS-1:0]       den,
	output jvls_pkg::jvls_div_stat_t              stat,
	output logic [jvls_pkg::QUOT_BITS-1:0]        quotient
);
	import jvls_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] den_q;
	logic [QUOT_BITS-1:0]  quo_q;
	logic [VALUE_BITS+1:0] diff;
	logic                  borrow;

	assign diff   = {1'b0, rem_q, 1'b0} - {2'b00, den_q};
	assign borrow = diff[VALUE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUOT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (borrow) begin
				rem_q <= {rem_q[VALUE_BITS-2:0], 1'b0};
			end else begin
				rem_q <= diff[VALUE_BITS-1:0];
			end
			quo_q <= {quo_q[QUOT_BITS-2:0], ~borrow};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q) else $error("partial remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q) else $error("done without a finished run");
`endif

endmodule

/* rtl/core/joint_velocity_limit_scaler.sv */
// Top level: per-list minimum of velocity limit scaling factors.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_stall    | velocity, min_velocity, max_velocity,
//           |                        | velocity_limited, last_variable
//  output   | out_valid / out_stall  | scale_factor (Q1.16, 65536 = 1.0)
//  config   | override_scale_we      | override_scale
//
// One item per transfer; in_stall holds off the next item until the current one is
// finished, which takes longer when the ratio needs the divider.
// Reset clears the override, the list state and the output valid flag.
// A last item waits in its final state until the output register is free.
module joint_velocity_limit_scaler (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   override_scale_we,
	input  logic [jvls_pkg::SCALE_BITS-1:0]        override_scale,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] velocity,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] min_velocity,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] max_velocity,
	input  logic                                   velocity_limited,
	input  logic                                   last_variable,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [jvls_pkg::SCALE_BITS-1:0]        scale_factor
);
	import jvls_pkg::*;

	jvls_state_t state_q, state_d;

	logic [SCALE_BITS-1:0]        override_q;
	logic signed [VALUE_BITS-1:0] vel_q, lo_q, hi_q, clamp_q;
	logic                         limited_q, last_q;
	logic [SCALE_BITS-1:0]        min_q;
	logic                         in_list_q;
	logic                         out_valid_q;
	logic [SCALE_BITS-1:0]        scale_q;

	logic                         accept;
	logic [SCALE_BITS-1:0]        start_val;
	logic signed [VALUE_BITS-1:0] clamp_val;
	logic [VALUE_BITS-1:0]        num_mag, den_mag;
	logic                         ratio_zero;
	logic                         active;
	logic                         out_free;
	logic                         fold_en;
	logic [SCALE_BITS-1:0]        fold_val;
	logic                         div_start;
	logic                         emit;
	jvls_div_stat_t               div_stat;
	logic [QUOT_BITS-1:0]         div_quo;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (override_q < OVERRIDE_MIN || override_q > SCALE_ONE) begin
			start_val = SCALE_ONE;
		end else begin
			start_val = override_q;
		end
	end

	always_comb begin
		if (vel_q < lo_q) begin
			clamp_val = lo_q;
		end else if (hi_q < vel_q) begin
			clamp_val = hi_q;
		end else begin
			clamp_val = vel_q;
		end
	end

	assign num_mag    = clamp_q[VALUE_BITS-1] ? VALUE_BITS'(-clamp_q) : VALUE_BITS'(clamp_q);
	assign den_mag    = vel_q[VALUE_BITS-1] ? VALUE_BITS'(-vel_q) : VALUE_BITS'(vel_q);
	assign ratio_zero = (clamp_q == '0) || (clamp_q[VALUE_BITS-1] != vel_q[VALUE_BITS-1]);
	assign active     = limited_q && (vel_q != '0);

	always_comb begin
		state_d   = state_q;
		fold_en   = 1'b0;
		fold_val  = SCALE_ONE;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_FINISH;
				if (active) begin
					if (ratio_zero) begin
						fold_en  = 1'b1;
						fold_val = '0;
					end else if (num_mag >= den_mag) begin
						fold_en  = 1'b1;
						fold_val = SCALE_ONE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					fold_en  = 1'b1;
					fold_val = SCALE_BITS'(div_quo);
					state_d  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			override_q  <= '0;
			in_list_q   <= 1'b0;
			out_valid_q <= 1'b0;
			min_q       <= '0;
		end else begin
			state_q <= state_d;
			if (override_scale_we) begin
				override_q <= override_scale;
			end
			if (accept && !in_list_q) begin
				min_q     <= start_val;
				in_list_q <= 1'b1;
			end else if (fold_en && fold_val < min_q) begin
				min_q <= fold_val;
			end
			if (emit) begin
				in_list_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vel_q     <= velocity;
			lo_q      <= min_velocity;
			hi_q      <= max_velocity;
			limited_q <= velocity_limited;
			last_q    <= last_variable;
		end
		if (state_q == ST_CLAMP) begin
			clamp_q <= clamp_val;
		end
		if (emit) begin
			scale_q <= min_q;
		end
	end

	jvls_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_mag),
		.den      (den_mag),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign out_valid    = out_valid_q;
	assign scale_factor = scale_q;

`ifndef SYNTHESIS
	a_min_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_list_q |-> min_q <= SCALE_ONE) else $error("running minimum above one");
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_stat.busy || div_stat.done)
		else $error("waiting on an idle divider");
	a_emit_list: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> in_list_q && last_q) else $error("result outside a list");
	a_out_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> scale_q <= SCALE_ONE) else $error("scale factor above one");
`endif

endmodule

/* tb/jvls_checker.sv */
`timescale 1ns / 1ps
// Checker for the joint velocity limit scaler: predicts list minimums and compares results.
module jvls_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   override_scale_we,
	input  logic [jvls_pkg::SCALE_BITS-1:0]        override_scale,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] velocity,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] min_velocity,
	input  logic signed [jvls_pkg::VALUE_BITS-1:0] max_velocity,
	input  logic                                   velocity_limited,
	input  logic                                   last_variable,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic [jvls_pkg::SCALE_BITS-1:0]        scale_factor,
	output int                                     mismatch_count,
	output int                                     pending_scales,
	output int                                     scales_checked,
	output int                                     items_seen
);
	import jvls_pkg::*;

	typedef logic signed [VALUE_BITS-1:0] vel_t;
	typedef logic [SCALE_BITS-1:0] scale_t;

	scale_t override_copy;
	scale_t list_min;
	logic   list_open;
	scale_t scale_queue [$];

	function automatic scale_t start_scale(scale_t ovr);
		if (ovr < OVERRIDE_MIN)
			return SCALE_ONE;
		return (ovr > SCALE_ONE) ? SCALE_ONE : ovr;
	endfunction

	// floor(|clamped| / |vel| * 65536), capped at 65536, zero when the clamp crosses or hits zero
	function automatic scale_t limit_ratio(vel_t vel, vel_t lo, vel_t hi);
		vel_t                              clamped;
		logic signed [VALUE_BITS:0]        cx, vx;
		logic [VALUE_BITS:0]               num, den;
		logic [VALUE_BITS+QUOT_BITS:0]     quo;
		clamped = vel;
		if (clamped < lo)
			clamped = lo;
		else if (hi < clamped)
			clamped = hi;
		if (clamped == 0 || ((clamped < 0) != (vel < 0)))
			return '0;
		cx = clamped;
		vx = vel;
		num = (cx < 0) ? -cx : cx;
		den = (vx < 0) ? -vx : vx;
		if (num >= den)
			return SCALE_ONE;
		quo = {num, {QUOT_BITS{1'b0}}} / den;
		return quo[SCALE_BITS-1:0];
	endfunction

	always @(posedge clk) begin : watch
		scale_t ratio, want;
		if (!arst_n) begin
			override_copy = '0;
			list_min = '0;
			list_open = 1'b0;
			scale_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (scale_queue.size() == 0) begin
					mismatch_count++;
					$display("%0t: scale_factor %0d arrived with nothing expected",
						$time, scale_factor);
				end else begin
					want = scale_queue[0];
					scale_queue.delete(0);
					scales_checked++;
					if (scale_factor !== want) begin
						mismatch_count++;
						$display("%0t: scale_factor mismatch: expected %0d, got %0d",
							$time, want, scale_factor);
					end
				end
			end
			if (in_valid && !in_stall) begin
				items_seen++;
				if (!list_open) begin
					list_min = start_scale(override_copy);
					list_open = 1'b1;
				end
				if (velocity_limited && velocity != 0) begin
					ratio = limit_ratio(velocity, min_velocity, max_velocity);
					if (ratio < list_min)
						list_min = ratio;
				end
				if (last_variable) begin
					scale_queue = {scale_queue, list_min};
					list_open = 1'b0;
				end
			end
			if (override_scale_we)
				override_copy = override_scale;
		end
		pending_scales = scale_queue.size();
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the joint velocity limit scaler: stimulus, stalls and verdict.
module tb;
	import jvls_pkg::*;

	typedef logic signed [VALUE_BITS-1:0] vel_t;

	localparam int   CYCLE_LIMIT = 1_000_000;
	localparam int   PHASE_ITEMS = 188;
	localparam vel_t VEL_MIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam vel_t VEL_MAX     = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam vel_t ONE_Q16     = 1 << 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  override_scale_we = 1'b0;
	logic [SCALE_BITS-1:0] override_scale = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	vel_t                  velocity = '0;
	vel_t                  min_velocity = '0;
	vel_t                  max_velocity = '0;
	logic                  velocity_limited = 1'b0;
	logic                  last_variable = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SCALE_BITS-1:0] scale_factor;

	int mismatch_count, pending_scales, scales_checked, items_seen;
	int cycle_count = 0;
	int stall_run = 0;
	int lists_sent = 0;
	int settings_used = 0;
	logic calm = 1'b0;

	int override_plan [9] = '{655, 654, 656, 65536, 131071, 1, 32768, 0, -1};

	joint_velocity_limit_scaler dut (.*);
	jvls_checker mon (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 50);
	endfunction

	// result side: alternating runs of ready and stalled cycles
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall = 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			out_stall = ($urandom_range(0, 2) == 0);
			stall_run = out_stall ? idle_len() : $urandom_range(0, 15);
		end
	end

	task automatic write_override(int value);
		override_scale_we = 1'b1;
		override_scale = value[SCALE_BITS-1:0];
		settings_used++;
		@(negedge clk);
		override_scale_we = 1'b0;
	endtask

	task automatic send_item(vel_t vel, vel_t lo, vel_t hi, logic lim, logic last);
		int gap;
		gap = (calm || $urandom_range(0, 2) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		velocity = vel;
		min_velocity = lo;
		max_velocity = hi;
		velocity_limited = lim;
		last_variable = last;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (last)
			lists_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_scales != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic vel_t rand_value();
		vel_t w;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				w = $urandom >> $urandom_range(1, 31);
				return $urandom_range(0, 1) ? w : -w;
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return 1;
					2: return -1;
					3: return VEL_MIN;
					default: return VEL_MAX;
				endcase
			end
			default: return $urandom_range(0, 400) - 200;
		endcase
	endfunction

	task automatic send_random_list(inout int sent);
		int   len;
		vel_t vel, lo, hi;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			vel = rand_value();
			if ($urandom_range(0, 3) == 0) begin
				lo = rand_value();
				hi = rand_value();
			end else begin
				lo = -vel_t'($urandom >> $urandom_range(1, 31));
				hi = vel_t'($urandom >> $urandom_range(1, 31));
			end
			send_item(vel, lo, hi, $urandom_range(0, 4) != 0, i == len - 1);
			sent++;
		end
	endtask

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_override(0);
		// unbounded only
		send_item(100 * ONE_Q16, '0, '0, 1'b0, 1'b1);
		// zero velocity, full range at both extremes
		send_item('0, -ONE_Q16, ONE_Q16, 1'b1, 1'b0);
		send_item(VEL_MAX, VEL_MIN, VEL_MAX, 1'b1, 1'b0);
		send_item(VEL_MIN, VEL_MIN, VEL_MAX, 1'b1, 1'b1);
		// huge velocity against a tiny bound
		send_item(VEL_MAX, '0, 1, 1'b1, 1'b0);
		send_item(ONE_Q16, '0, '0, 1'b0, 1'b1);
		// plain ratios, then a clamp to the opposite sign
		send_item(2 * ONE_Q16, -ONE_Q16, ONE_Q16, 1'b1, 1'b0);
		send_item(-3 * ONE_Q16, -ONE_Q16, ONE_Q16, 1'b1, 1'b0);
		send_item(-1, ONE_Q16, 2 * ONE_Q16, 1'b1, 1'b1);
		// sign change through the upper bound
		send_item(5 * ONE_Q16, -3 * ONE_Q16, -ONE_Q16, 1'b1, 1'b1);
		// crossed bounds
		send_item(ONE_Q16, 3 * ONE_Q16, 2 * ONE_Q16, 1'b1, 1'b0);
		send_item(4 * ONE_Q16, 3 * ONE_Q16, 2 * ONE_Q16, 1'b1, 1'b1);
		// most negative velocity clamped to -1.0
		send_item(VEL_MIN, -ONE_Q16, VEL_MAX, 1'b1, 1'b1);
		// raw LSB ratios, clamped to zero
		send_item(3, -1, 1, 1'b1, 1'b0);
		send_item(-7, -5, VEL_MAX, 1'b1, 1'b0);
		send_item(1, '0, '0, 1'b1, 1'b1);
		send_item(-1, VEL_MIN, VEL_MAX, 1'b1, 1'b1);
		drain();

		foreach (override_plan[p]) begin
			write_override(override_plan[p] < 0 ? $urandom_range(655, 65535) : override_plan[p]);
			calm = (p == 2 || p == 6);
			sent = 0;
			while (sent < PHASE_ITEMS)
				send_random_list(sent);
			drain();
		end
		calm = 1'b0;

		$display("sent %0d velocity transfers in %0d lists over %0d override settings,",
			items_seen, lists_sent, settings_used);
		$display("with saturating, crossed and sign-flipped bounds; %0d scale factors checked",
			scales_checked);
		if (mismatch_count == 0 && pending_scales == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
